### src/tcoe_pkg.sv
package tcoe_pkg;

  localparam int POS_W      = 14;
  localparam int REGION_W   = 15;
  localparam int CIDX_W     = 2;
  localparam int OP_W       = 2;
  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 15;
  localparam int SUM_W      = POS_W + 2;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = 1;
  localparam int QCNT_W  = QPTR_W + 1;

  localparam logic [REGION_W-1:0] REGION_RESET = 15'd5461;
  localparam logic [BYTE_W-1:0]   ATTR_RESET   = 8'd7;

  localparam logic [OP_W-1:0] OP_PUT         = 2'd0;
  localparam logic [OP_W-1:0] OP_SCROLL_UP   = 2'd1;
  localparam logic [OP_W-1:0] OP_SCROLL_DOWN = 2'd2;
  localparam logic [OP_W-1:0] OP_SELECT      = 2'd3;

  localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [BYTE_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [BYTE_W-1:0] CH_BLANK     = 8'h20;

  localparam logic [POS_W-1:0] CRTC_START_H  = 14'd12;
  localparam logic [POS_W-1:0] CRTC_START_L  = 14'd13;
  localparam logic [POS_W-1:0] CRTC_CURSOR_H = 14'd14;
  localparam logic [POS_W-1:0] CRTC_CURSOR_L = 14'd15;

  localparam logic KIND_CELL = 1'b0;
  localparam logic KIND_CRTC = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_REGION = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTR   = 1'b1;

  typedef enum logic [2:0] {
    IK_NEWLINE,
    IK_BACKSPACE,
    IK_PRINT,
    IK_SCROLL_UP,
    IK_SCROLL_DOWN,
    IK_SELECT
  } item_kind_t;

  typedef struct packed {
    item_kind_t               kind;
    logic [CIDX_W-1:0]        console;
    logic [BYTE_W-1:0]        ch;
  } item_t;

  typedef enum logic [3:0] {
    BS_IDLE,
    BS_DIV,
    BS_MUL,
    BS_CHAR,
    BS_CELL,
    BS_CHECK,
    BS_SCROLL,
    BS_CUR_H,
    BS_CUR_L,
    BS_START_H,
    BS_START_L
  } back_state_t;

endpackage

### src/text_console_output_engine.sv
// Text console output engine: virtual consoles sharing one video memory.
// Request channel (item_valid / item_stall): opcode, console_index and
// char_code. Put character, scroll up, scroll down or select console.
// Requests naming a console at or above NUM_CONSOLES are taken and dropped.
// A two-entry queue takes requests while the sequencer works on earlier ones.
// Result channel (result_valid / result_stall): video cell writes and CRTC
// register writes, one at a time, from an output register; last marks the
// final result of a request. When the receiver stalls, the result holds and
// the sequencer waits; the queue keeps accepting until it is full.
// Every request ends with cursor register writes, followed by view start
// register writes when it names the active console; a put that moves the
// cursor past the end of the view scrolls it down and writes them twice.
// Configuration (cfg_valid / cfg_ready, always ready): index 0 region size in
// cells, saturated to VMEM_CELLS / NUM_CONSOLES; index 1 character attribute.
// Write it only while no request is in flight.
// Reset: region size 5461, attribute 7, console 0 active, every cursor and
// view start at the base of its region, queue and output empty.
module text_console_output_engine #(
  parameter int NUM_CONSOLES = 3,
  parameter int SCREEN_COLS  = 80,
  parameter int SCREEN_CELLS = 2000,
  parameter int VMEM_CELLS   = 16384
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic [tcoe_pkg::OP_W-1:0]         opcode,
  input  logic [tcoe_pkg::CIDX_W-1:0]       console_index,
  input  logic [tcoe_pkg::BYTE_W-1:0]       char_code,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic                              kind,
  output logic [tcoe_pkg::POS_W-1:0]        address,
  output logic [tcoe_pkg::BYTE_W-1:0]       byte_value,
  output logic [tcoe_pkg::BYTE_W-1:0]       attribute,
  output logic                              last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tcoe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tcoe_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import tcoe_pkg::*;

  localparam int CAP = VMEM_CELLS / NUM_CONSOLES;

  logic [REGION_W-1:0] region_cells;
  logic [REGION_W-1:0] region;
  logic [BYTE_W-1:0]   char_attr;
  item_t               head;
  logic                head_valid;
  logic                pop;

  assign cfg_ready = 1'b1;
  assign region    = (region_cells > REGION_W'(CAP)) ? REGION_W'(CAP) : region_cells;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_cells <= REGION_RESET;
      char_attr    <= ATTR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_REGION: region_cells <= cfg_data[REGION_W-1:0];
        CFG_ATTR:   char_attr    <= cfg_data[BYTE_W-1:0];
        default:    region_cells <= region_cells;
      endcase
    end
  end

  tcoe_front #(
    .NUM_CONSOLES (NUM_CONSOLES)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .opcode        (opcode),
    .console_index (console_index),
    .char_code     (char_code),
    .head          (head),
    .head_valid    (head_valid),
    .pop           (pop)
  );

  tcoe_back #(
    .NUM_CONSOLES (NUM_CONSOLES),
    .SCREEN_COLS  (SCREEN_COLS),
    .SCREEN_CELLS (SCREEN_CELLS),
    .VMEM_CELLS   (VMEM_CELLS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_valid   (head_valid),
    .pop          (pop),
    .region       (region),
    .char_attr    (char_attr),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .address      (address),
    .byte_value   (byte_value),
    .attribute    (attribute),
    .last         (last)
  );

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue popped while empty");

  a_crtc_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind == KIND_CRTC |-> attribute == '0 &&
      (address == CRTC_START_H || address == CRTC_START_L ||
       address == CRTC_CURSOR_H || address == CRTC_CURSOR_L))
    else $error("CRTC write with bad register or attribute");

  a_cell_not_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind == KIND_CELL |-> !last)
    else $error("cell write marked as final result");
`endif

endmodule

### src/tcoe_front.sv
module tcoe_front #(
  parameter int NUM_CONSOLES = 3
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic [tcoe_pkg::OP_W-1:0]     opcode,
  input  logic [tcoe_pkg::CIDX_W-1:0]   console_index,
  input  logic [tcoe_pkg::BYTE_W-1:0]   char_code,
  output tcoe_pkg::item_t               head,
  output logic                          head_valid,
  input  logic                          pop
);
  import tcoe_pkg::*;

  item_t              queue [QDEPTH];
  item_t              entry;
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               full;
  logic               in_range;
  logic               push;

  always_comb begin
    entry.console = console_index;
    entry.ch      = char_code;
    case (opcode)
      OP_PUT: begin
        if (char_code == CH_NEWLINE) begin
          entry.kind = IK_NEWLINE;
        end else if (char_code == CH_BACKSPACE) begin
          entry.kind = IK_BACKSPACE;
        end else begin
          entry.kind = IK_PRINT;
        end
      end
      OP_SCROLL_UP:   entry.kind = IK_SCROLL_UP;
      OP_SCROLL_DOWN: entry.kind = IK_SCROLL_DOWN;
      default:        entry.kind = IK_SELECT;
    endcase
  end

  assign full       = (count == QCNT_W'(QDEPTH));
  assign in_range   = ({1'b0, console_index} < (CIDX_W + 1)'(NUM_CONSOLES));
  assign push       = item_valid && !full && in_range;
  assign item_stall = full;
  assign head_valid = (count != '0);
  assign head       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= entry;
    end
  end

endmodule

### src/tcoe_back.sv
module tcoe_back #(
  parameter int NUM_CONSOLES = 3,
  parameter int SCREEN_COLS  = 80,
  parameter int SCREEN_CELLS = 2000,
  parameter int VMEM_CELLS   = 16384
) (
  input  logic                            clk,
  input  logic                            rst,
  input  tcoe_pkg::item_t                 head,
  input  logic                            head_valid,
  output logic                            pop,
  input  logic [tcoe_pkg::REGION_W-1:0]   region,
  input  logic [tcoe_pkg::BYTE_W-1:0]     char_attr,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic                            kind,
  output logic [tcoe_pkg::POS_W-1:0]      address,
  output logic [tcoe_pkg::BYTE_W-1:0]     byte_value,
  output logic [tcoe_pkg::BYTE_W-1:0]     attribute,
  output logic                            last
);
  import tcoe_pkg::*;

  localparam int IDX_W      = (NUM_CONSOLES > 1) ? $clog2(NUM_CONSOLES) : 1;
  localparam int CAP        = VMEM_CELLS / NUM_CONSOLES;
  localparam int RST_REGION = (int'(REGION_RESET) > CAP) ? CAP : int'(REGION_RESET);
  localparam int DIV_SHIFT  = 24;
  localparam int DIV_MULT   = (1 << DIV_SHIFT) / SCREEN_COLS + 1;
  localparam int MULT_W     = $clog2(DIV_MULT + 1);
  localparam int PROD_W     = POS_W + MULT_W;
  localparam int QUOT_W     = $clog2(((1 << POS_W) - 1) / SCREEN_COLS + 2);
  localparam int COLS_W     = $clog2(SCREEN_COLS + 1);
  localparam int NL_W       = QUOT_W + 1 + COLS_W;
  localparam int ADD_W      = ((NL_W > POS_W) ? NL_W : POS_W) + 1;

  localparam logic [MULT_W-1:0] MULT_C = MULT_W'(DIV_MULT);
  localparam logic [SUM_W-1:0]  COLS_S = SUM_W'(SCREEN_COLS);
  localparam logic [SUM_W-1:0]  CELLS_S = SUM_W'(SCREEN_CELLS);
  localparam logic [POS_W-1:0]  COLS_P = POS_W'(SCREEN_COLS);

  back_state_t        state;
  back_state_t        state_next;
  logic [POS_W-1:0]   cursor [NUM_CONSOLES];
  logic [POS_W-1:0]   view   [NUM_CONSOLES];
  logic [IDX_W-1:0]   active;
  logic               match;
  logic               more;

  item_kind_t         ikind;
  logic [IDX_W-1:0]   n_w;
  logic [BYTE_W-1:0]  ch_w;
  logic [POS_W-1:0]   base_w;
  logic [POS_W-1:0]   cur_w;
  logic [POS_W-1:0]   view_w;
  logic [QUOT_W-1:0]  quot;
  logic [POS_W-1:0]   nl_pos;
  logic [POS_W-1:0]   cell_addr;
  logic [BYTE_W-1:0]  cell_byte;

  logic [IDX_W-1:0]   head_n;
  logic [POS_W-1:0]   head_base;
  logic [POS_W-1:0]   diff;
  logic [PROD_W-1:0]  prod;
  logic [NL_W-1:0]    nl_step;
  logic [ADD_W-1:0]   nl_sum;
  logic [SUM_W-1:0]   lim;
  logic [SUM_W-1:0]   view_end;
  logic               scroll_hit;
  logic               out_free;

  logic               cur_we;
  logic [POS_W-1:0]   cur_new;
  logic               view_we;
  logic [POS_W-1:0]   view_new;
  logic               emit;
  logic               e_kind;
  logic [POS_W-1:0]   e_addr;
  logic [BYTE_W-1:0]  e_byte;
  logic [BYTE_W-1:0]  e_attr;
  logic               e_last;

  assign head_n     = head.console[IDX_W-1:0];
  assign head_base  = POS_W'(head_n * region);
  assign diff       = cur_w - base_w;
  assign prod       = PROD_W'(diff) * PROD_W'(MULT_C);
  assign nl_step    = NL_W'(NL_W'(quot) + 1'b1) * NL_W'(SCREEN_COLS);
  assign nl_sum     = ADD_W'(base_w) + ADD_W'(nl_step);
  assign lim        = SUM_W'(base_w) + SUM_W'(region);
  assign view_end   = SUM_W'(view_w) + CELLS_S;
  assign scroll_hit = (SUM_W'(cur_w) >= view_end);
  assign out_free   = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    cur_we     = 1'b0;
    cur_new    = cur_w;
    view_we    = 1'b0;
    view_new   = view_w;
    emit       = 1'b0;
    e_kind     = KIND_CRTC;
    e_addr     = CRTC_CURSOR_H;
    e_byte     = '0;
    e_attr     = '0;
    e_last     = 1'b0;
    case (state)
      BS_IDLE: begin
        if (head_valid) begin
          pop = 1'b1;
          case (head.kind)
            IK_NEWLINE:                   state_next = BS_DIV;
            IK_BACKSPACE, IK_PRINT:       state_next = BS_CHAR;
            IK_SCROLL_UP, IK_SCROLL_DOWN: state_next = BS_SCROLL;
            default:                      state_next = BS_CUR_H;
          endcase
        end
      end
      BS_DIV: state_next = BS_MUL;
      BS_MUL: state_next = BS_CHAR;
      BS_CHAR: begin
        state_next = BS_CHECK;
        case (ikind)
          IK_NEWLINE: begin
            if (SUM_W'(cur_w) + COLS_S < lim) begin
              cur_we  = 1'b1;
              cur_new = nl_pos;
            end
          end
          IK_BACKSPACE: begin
            if (cur_w > base_w) begin
              cur_we     = 1'b1;
              cur_new    = cur_w - 1'b1;
              state_next = BS_CELL;
            end
          end
          default: begin
            if (SUM_W'(cur_w) + SUM_W'(1) < lim) begin
              cur_we     = 1'b1;
              cur_new    = cur_w + 1'b1;
              state_next = BS_CELL;
            end
          end
        endcase
      end
      BS_CELL: begin
        if (out_free) begin
          emit       = 1'b1;
          e_kind     = KIND_CELL;
          e_addr     = cell_addr;
          e_byte     = cell_byte;
          e_attr     = char_attr;
          state_next = BS_CHECK;
        end
      end
      BS_CHECK: begin
        state_next = scroll_hit ? BS_SCROLL : BS_CUR_H;
      end
      BS_SCROLL: begin
        state_next = BS_CUR_H;
        if (ikind == IK_SCROLL_UP) begin
          if (view_w > base_w) begin
            view_we  = 1'b1;
            view_new = view_w - COLS_P;
          end
        end else if (view_end < lim) begin
          view_we  = 1'b1;
          view_new = view_w + COLS_P;
        end
      end
      BS_CUR_H: begin
        if (out_free) begin
          emit       = 1'b1;
          e_addr     = CRTC_CURSOR_H;
          e_byte     = BYTE_W'(cur_w >> 8);
          state_next = BS_CUR_L;
        end
      end
      BS_CUR_L: begin
        if (out_free) begin
          emit   = 1'b1;
          e_addr = CRTC_CURSOR_L;
          e_byte = cur_w[BYTE_W-1:0];
          e_last = !match && !more;
          if (match) begin
            state_next = BS_START_H;
          end else begin
            state_next = more ? BS_CUR_H : BS_IDLE;
          end
        end
      end
      BS_START_H: begin
        if (out_free) begin
          emit       = 1'b1;
          e_addr     = CRTC_START_H;
          e_byte     = BYTE_W'(view_w >> 8);
          state_next = BS_START_L;
        end
      end
      BS_START_L: begin
        if (out_free) begin
          emit       = 1'b1;
          e_addr     = CRTC_START_L;
          e_byte     = view_w[BYTE_W-1:0];
          e_last     = !more;
          state_next = more ? BS_CUR_H : BS_IDLE;
        end
      end
      default: state_next = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
      match  <= 1'b0;
      more   <= 1'b0;
      for (int i = 0; i < NUM_CONSOLES; i++) begin
        cursor[i] <= POS_W'(i * RST_REGION);
        view[i]   <= POS_W'(i * RST_REGION);
      end
    end else begin
      if (pop) begin
        more  <= 1'b0;
        match <= (head.kind == IK_SELECT) || (head_n == active);
        if (head.kind == IK_SELECT) begin
          active <= head_n;
        end
      end else if (state == BS_CHECK && scroll_hit) begin
        more <= 1'b1;
      end else if (emit && state_next == BS_CUR_H) begin
        more <= 1'b0;
      end
      if (cur_we) begin
        cursor[n_w] <= cur_new;
      end
      if (view_we) begin
        view[n_w] <= view_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ikind  <= head.kind;
      n_w    <= head_n;
      ch_w   <= head.ch;
      base_w <= head_base;
      cur_w  <= cursor[head_n];
      view_w <= view[head_n];
    end else begin
      if (cur_we) begin
        cur_w <= cur_new;
      end
      if (view_we) begin
        view_w <= view_new;
      end
    end
    if (state == BS_DIV) begin
      quot <= QUOT_W'(prod >> DIV_SHIFT);
    end
    if (state == BS_MUL) begin
      nl_pos <= nl_sum[POS_W-1:0];
    end
    if (state == BS_CHAR) begin
      cell_addr <= (ikind == IK_BACKSPACE) ? cur_w - 1'b1 : cur_w;
      cell_byte <= (ikind == IK_BACKSPACE) ? CH_BLANK : ch_w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind       <= e_kind;
      address    <= e_addr;
      byte_value <= e_byte;
      attribute  <= e_attr;
      last       <= e_last;
    end
  end

endmodule

### tb/sv/text_console_output_engine_tb.sv
`timescale 1ns / 1ps

module text_console_output_engine_tb;
  import tcoe_pkg::*;

  localparam int unsigned NUM_CONSOLES = 3;
  localparam int unsigned SCREEN_COLS = 80;
  localparam int unsigned SCREEN_CELLS = 2000;
  localparam int unsigned VMEM_CELLS = 16384;
  localparam int unsigned POS_MASK = (1 << POS_W) - 1;
  localparam int RESET_CYCLES = 12;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES = 120;
  localparam int STALL_LIMIT = 1000;

  typedef struct packed {
    logic kind;
    logic [POS_W-1:0] address;
    logic [BYTE_W-1:0] byte_value;
    logic [BYTE_W-1:0] attribute;
    logic last;
  } console_write_t;

  logic clk;
  logic rst;
  logic item_valid;
  logic item_stall;
  logic [OP_W-1:0] opcode;
  logic [CIDX_W-1:0] console_index;
  logic [BYTE_W-1:0] char_code;
  logic result_valid;
  logic result_stall;
  logic kind;
  logic [POS_W-1:0] address;
  logic [BYTE_W-1:0] byte_value;
  logic [BYTE_W-1:0] attribute;
  logic last;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  console_write_t pending_writes[$];
  console_write_t got_write;
  console_write_t want_write;
  logic [REGION_W-1:0] region_cfg;
  logic [BYTE_W-1:0] attr_cfg;
  logic [POS_W-1:0] cursor_pos [NUM_CONSOLES];
  logic [POS_W-1:0] view_pos [NUM_CONSOLES];
  logic [CIDX_W-1:0] active_con;

  bit steady;
  bit hold_results;
  int fail_count;
  int idle_cycles;

  text_console_output_engine #(
    .NUM_CONSOLES(NUM_CONSOLES),
    .SCREEN_COLS(SCREEN_COLS),
    .SCREEN_CELLS(SCREEN_CELLS),
    .VMEM_CELLS(VMEM_CELLS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .opcode(opcode),
    .console_index(console_index),
    .char_code(char_code),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .kind(kind),
    .address(address),
    .byte_value(byte_value),
    .attribute(attribute),
    .last(last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned region_cells();
    int unsigned cap;
    cap = VMEM_CELLS / NUM_CONSOLES;
    return (32'(region_cfg) > cap) ? cap : 32'(region_cfg);
  endfunction

  function automatic void reset_console_state();
    region_cfg = REGION_RESET;
    attr_cfg = ATTR_RESET;
    active_con = '0;
    for (int unsigned n = 0; n < NUM_CONSOLES; n++) begin
      cursor_pos[n] = POS_W'(n * region_cells());
      view_pos[n] = POS_W'(n * region_cells());
    end
    pending_writes.delete();
  endfunction

  function automatic void push_write(logic k, logic [POS_W-1:0] addr,
                                     logic [BYTE_W-1:0] value, logic [BYTE_W-1:0] attr);
    console_write_t w;
    w.kind = k;
    w.address = addr;
    w.byte_value = value;
    w.attribute = attr;
    w.last = 1'b0;
    pending_writes.push_back(w);
  endfunction

  function automatic void push_cursor(int unsigned n);
    push_write(KIND_CRTC, CRTC_CURSOR_H, BYTE_W'(cursor_pos[n] >> 8), '0);
    push_write(KIND_CRTC, CRTC_CURSOR_L, cursor_pos[n][7:0], '0);
  endfunction

  function automatic void push_start(int unsigned n);
    push_write(KIND_CRTC, CRTC_START_H, BYTE_W'(view_pos[n] >> 8), '0);
    push_write(KIND_CRTC, CRTC_START_L, view_pos[n][7:0], '0);
  endfunction

  function automatic void push_regs(int unsigned n);
    push_cursor(n);
    if (n == 32'(active_con))
      push_start(n);
  endfunction

  function automatic void model_scroll(int unsigned n, bit down);
    int unsigned r, base, v;
    r = region_cells();
    base = n * r;
    v = 32'(view_pos[n]);
    if (down) begin
      if (v + SCREEN_CELLS < base + r)
        view_pos[n] = POS_W'(v + SCREEN_COLS);
    end else if (v > base) begin
      view_pos[n] = POS_W'(v - SCREEN_COLS);
    end
    push_regs(n);
  endfunction

  function automatic void model_put_char(int unsigned n, logic [BYTE_W-1:0] ch);
    int unsigned r, base, cur;
    r = region_cells();
    base = n * r;
    cur = 32'(cursor_pos[n]);
    if (ch == CH_NEWLINE) begin
      if (cur + SCREEN_COLS < base + r)
        cur = base + SCREEN_COLS * (((cur - base) & POS_MASK) / SCREEN_COLS + 1);
    end else if (ch == CH_BACKSPACE) begin
      if (cur > base) begin
        cur = cur - 1;
        push_write(KIND_CELL, POS_W'(cur), CH_BLANK, attr_cfg);
      end
    end else if (cur + 1 < base + r) begin
      push_write(KIND_CELL, POS_W'(cur), ch, attr_cfg);
      cur = cur + 1;
    end
    cursor_pos[n] = POS_W'(cur);
    if (32'(cursor_pos[n]) >= 32'(view_pos[n]) + SCREEN_CELLS)
      model_scroll(n, 1'b1);
    push_regs(n);
  endfunction

  function automatic void predict_console_writes(logic [OP_W-1:0] op, logic [CIDX_W-1:0] con,
                                                 logic [BYTE_W-1:0] ch);
    int unsigned n;
    int queued_at_entry;
    console_write_t w;
    n = 32'(con);
    queued_at_entry = pending_writes.size();
    if (n >= NUM_CONSOLES)
      return;
    case (op)
      OP_PUT: model_put_char(n, ch);
      OP_SCROLL_UP: model_scroll(n, 1'b0);
      OP_SCROLL_DOWN: model_scroll(n, 1'b1);
      default: begin
        active_con = con;
        push_cursor(n);
        push_start(n);
      end
    endcase
    if (pending_writes.size() > queued_at_entry) begin
      w = pending_writes.pop_back();
      w.last = 1'b1;
      pending_writes.push_back(w);
    end
  endfunction

  task automatic send_item(input item_kind_t what, input logic [CIDX_W-1:0] con,
                           input logic [BYTE_W-1:0] ch);
    int gap;
    logic [OP_W-1:0] op;
    logic [BYTE_W-1:0] code;
    code = ch;
    case (what)
      IK_NEWLINE: begin
        op = OP_PUT;
        code = CH_NEWLINE;
      end
      IK_BACKSPACE: begin
        op = OP_PUT;
        code = CH_BACKSPACE;
      end
      IK_PRINT: op = OP_PUT;
      IK_SCROLL_UP: op = OP_SCROLL_UP;
      IK_SCROLL_DOWN: op = OP_SCROLL_DOWN;
      default: op = OP_SELECT;
    endcase
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    opcode <= op;
    console_index <= con;
    char_code <= code;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    predict_console_writes(op, con, code);
  endtask

  task automatic settle();
    item_valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [REGION_W-1:0] region, input logic [BYTE_W-1:0] attr);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_REGION;
    cfg_data <= CFG_DATA_W'(region);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    region_cfg = region;
    cfg_index <= CFG_ATTR;
    cfg_data <= CFG_DATA_W'(attr);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    attr_cfg = attr;
    cfg_valid <= 1'b0;
  endtask

  task automatic test_select_consoles();
    send_item(IK_SELECT, CIDX_W'(1), 8'hA5);
    send_item(IK_SELECT, CIDX_W'(2), 8'h5A);
    send_item(IK_SELECT, CIDX_W'(3), 8'hFF);
    send_item(IK_SELECT, CIDX_W'(0), 8'h00);
  endtask

  task automatic test_put_cases();
    send_item(IK_BACKSPACE, CIDX_W'(0), 8'h00);
    send_item(IK_PRINT, CIDX_W'(0), 8'h00);
    send_item(IK_PRINT, CIDX_W'(0), 8'hFF);
    send_item(IK_PRINT, CIDX_W'(0), 8'h7F);
    send_item(IK_PRINT, CIDX_W'(0), 8'h09);
    send_item(IK_PRINT, CIDX_W'(0), 8'h0B);
    send_item(IK_NEWLINE, CIDX_W'(0), 8'h00);
    send_item(IK_BACKSPACE, CIDX_W'(0), 8'h00);
    send_item(IK_PRINT, CIDX_W'(1), 8'h41);
    send_item(IK_NEWLINE, CIDX_W'(2), 8'h00);
    send_item(IK_PRINT, CIDX_W'(3), 8'h42);
  endtask

  task automatic test_scroll_cases();
    send_item(IK_SCROLL_UP, CIDX_W'(0), 8'h00);
    send_item(IK_SCROLL_DOWN, CIDX_W'(0), 8'hFF);
    send_item(IK_SCROLL_DOWN, CIDX_W'(1), 8'h00);
    send_item(IK_SCROLL_UP, CIDX_W'(0), 8'h00);
    send_item(IK_SCROLL_UP, CIDX_W'(3), 8'h00);
    send_item(IK_SCROLL_DOWN, CIDX_W'(3), 8'h00);
  endtask

  task automatic test_attribute_extremes();
    set_config(REGION_RESET, 8'h00);
    send_item(IK_PRINT, CIDX_W'(0), 8'h61);
    set_config(REGION_RESET, 8'hFF);
    send_item(IK_PRINT, CIDX_W'(2), 8'h62);
  endtask

  task automatic test_fill_console();
    int unsigned limit;
    set_config(REGION_RESET, BYTE_W'($urandom_range(0, 255)));
    limit = region_cells();
    steady = 1'b1;
    while (32'(cursor_pos[0]) + SCREEN_COLS < limit) begin
      if ($urandom_range(0, 5) == 0)
        send_item(IK_PRINT, CIDX_W'(0), BYTE_W'($urandom_range(0, 255)));
      else
        send_item(IK_NEWLINE, CIDX_W'(0), BYTE_W'($urandom));
    end
    steady = 1'b0;
    while (32'(cursor_pos[0]) + 1 < limit)
      send_item(IK_PRINT, CIDX_W'(0), BYTE_W'($urandom_range(32, 126)));
    repeat (2) send_item(IK_PRINT, CIDX_W'(0), BYTE_W'($urandom_range(32, 126)));
    repeat (3) send_item(IK_SCROLL_UP, CIDX_W'(0), BYTE_W'($urandom));
    repeat (2) send_item(IK_PRINT, CIDX_W'(0), BYTE_W'($urandom_range(32, 126)));
    send_item(IK_BACKSPACE, CIDX_W'(0), BYTE_W'($urandom));
  endtask

  task automatic test_backpressure();
    steady = 1'b1;
    hold_results = 1'b1;
    repeat (12) send_item(IK_PRINT, CIDX_W'(1), BYTE_W'($urandom_range(0, 255)));
    steady = 1'b0;
  endtask

  task automatic random_session(input int count, input int unsigned focus);
    int unsigned pick;
    logic [CIDX_W-1:0] con;
    logic [BYTE_W-1:0] ch;
    repeat (count) begin
      con = ($urandom_range(0, 4) != 0) ? CIDX_W'(focus) : CIDX_W'($urandom_range(0, 3));
      ch = BYTE_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 38)
        send_item(IK_NEWLINE, con, ch);
      else if (pick < 68)
        send_item(IK_PRINT, con, ch);
      else if (pick < 76)
        send_item(IK_BACKSPACE, con, ch);
      else if (pick < 83)
        send_item(IK_SCROLL_UP, con, ch);
      else if (pick < 90)
        send_item(IK_SCROLL_DOWN, con, ch);
      else if (pick < 96)
        send_item(IK_SELECT, con, ch);
      else
        send_item(item_kind_t'($urandom_range(0, 5)), CIDX_W'(3), ch);
    end
  endtask

  task automatic test_random_sessions();
    int unsigned regions [5];
    logic [BYTE_W-1:0] attrs [5];
    regions[0] = VMEM_CELLS;
    regions[1] = SCREEN_CELLS;
    regions[2] = $urandom_range(2001, 5460);
    regions[3] = $urandom_range(5462, 16383);
    regions[4] = 32'(REGION_RESET);
    attrs[0] = 8'h00;
    attrs[1] = 8'hFF;
    for (int p = 2; p < 5; p++)
      attrs[p] = BYTE_W'($urandom_range(0, 255));
    for (int p = 0; p < 5; p++) begin
      set_config(REGION_W'(regions[p]), attrs[p]);
      steady = ($urandom_range(0, 3) == 0);
      random_session(20, $urandom_range(0, NUM_CONSOLES - 1));
      random_session(20, $urandom_range(0, NUM_CONSOLES - 1));
    end
    steady = 1'b0;
  endtask

  initial begin : result_sink
    int gap;
    result_stall <= 1'b1;
    @(negedge rst);
    forever begin
      if (hold_results) begin
        hold_results = 1'b0;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        result_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      result_stall <= 1'b0;
      @(posedge clk);
      while (!(result_valid && !result_stall)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      got_write = {kind, address, byte_value, attribute, last};
      if (pending_writes.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected write, actual kind %0d addr %0d byte %0h attr %0h last %0d",
                 $time, kind, address, byte_value, attribute, last);
      end else begin
        want_write = pending_writes.pop_front();
        if (got_write !== want_write) begin
          fail_count++;
          $display("%0t: expected kind %0d addr %0d byte %0h attr %0h last %0d, %s %0d %0d %0h %0h %0d",
                   $time, want_write.kind, want_write.address, want_write.byte_value,
                   want_write.attribute, want_write.last, "actual",
                   kind, address, byte_value, attribute, last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    item_valid <= 1'b0;
    opcode <= OP_PUT;
    console_index <= '0;
    char_code <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_REGION;
    cfg_data <= '0;
    rst <= 1'b1;
    steady = 1'b0;
    hold_results = 1'b0;
    reset_console_state();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_select_consoles();
    test_put_cases();
    test_scroll_cases();
    test_attribute_extremes();
    test_fill_console();
    test_backpressure();
    test_random_sessions();
    settle();
    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

### sim.f
src/tcoe_pkg.sv
src/tcoe_front.sv
src/tcoe_back.sv
src/text_console_output_engine.sv
tb/sv/text_console_output_engine_tb.sv
